// ----- rtl/bha_pkg.sv -----
package bha_pkg;

    localparam int ADDR_W   = 48;
    localparam int INDEX_W  = 10;
    localparam int COLS     = 64;
    localparam int COL_W    = 6;
    localparam int GROUP_W  = 3;
    localparam int ALIGN_W  = 4;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;

    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd4;

    // Register word indexes on the configuration port
    localparam logic [PADDR_W-3:0] REG_ALIGN = 1'b0;

    typedef struct packed {
        logic load;
        logic open_table;
        logic find_group;
        logic commit;
        logic fail;
    } t_cmd;

    typedef struct packed {
        logic need_table;
        logic at_limit;
    } t_stat;

    // Position of the lowest zero bit; the caller guarantees one exists.
    function automatic logic [GROUP_W-1:0] first_zero8(input logic [7:0] v);
        logic [GROUP_W-1:0] pos;
        pos = '0;
        for (int i = 7; i >= 0; i--) begin
            if (!v[i]) begin
                pos = GROUP_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ----- rtl/bha_ctrl.sv -----
module bha_ctrl
    import bha_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PICK  = 2'd1;
    localparam logic [1:0] S_GROUP = 2'd2;
    localparam logic [1:0] S_COL   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PICK;
                end
            end
            S_PICK: begin
                if (i_stat.need_table && i_stat.at_limit) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.open_table = i_stat.need_table;
                    n_state          = S_GROUP;
                end
            end
            S_GROUP: begin
                o_cmd.find_group = 1'b1;
                n_state          = S_COL;
            end
            S_COL: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/bha_dpath.sv -----
module bha_dpath
    import bha_pkg::*;
#(
    parameter int MAX_TABLES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [ADDR_W-1:0]  i_header_addr,
    input  logic [ALIGN_W-1:0] i_align_log2,
    output t_stat              o_stat,
    output logic               o_done,
    output logic               o_granted,
    output logic [INDEX_W-1:0] o_handle_index,
    output logic [ADDR_W-1:0]  o_block_addr
);

    localparam int CNT_W = $clog2(MAX_TABLES + 1);
    localparam int TBL_W = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int MEM_DEPTH = MAX_TABLES * COLS;
    localparam int MEM_AW = $clog2(MEM_DEPTH);

    // Tables fill in order and are never released, so every table below the
    // newest is full and only the newest one's bitmap needs to be kept.
    logic [CNT_W-1:0]  r_count;
    logic [TBL_W-1:0]  r_table;
    logic [COLS-1:0]   r_bitmap;
    logic [ADDR_W-1:0] r_head;
    logic [ADDR_W-1:0] r_rounded;
    logic [GROUP_W-1:0] r_group;
    logic [ADDR_W-1:0] r_entry [MEM_DEPTH];

    logic [ADDR_W-1:0] w_amask;
    logic [7:0]        w_group_full;
    logic [7:0]        w_byte;
    logic [COL_W-1:0]  w_col;
    logic [TBL_W+COL_W-1:0] w_handle;

    assign w_amask = (ADDR_W'(1) << i_align_log2) - ADDR_W'(1);

    always_comb begin
        for (int g = 0; g < 8; g++) begin
            w_group_full[g] = &r_bitmap[g*8 +: 8];
        end
    end

    assign w_byte   = r_bitmap[r_group*8 +: 8];
    assign w_col    = {r_group, first_zero8(w_byte)};
    assign w_handle = {r_table, w_col};

    assign o_stat.need_table = (r_count == '0) || (&r_bitmap);
    assign o_stat.at_limit   = (r_count == CNT_W'(MAX_TABLES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_bitmap <= '0;
            o_done   <= 1'b0;
        end else begin
            o_done <= i_cmd.commit || i_cmd.fail;
            if (i_cmd.open_table) begin
                r_count  <= r_count + CNT_W'(1);
                r_bitmap <= '0;
            end
            if (i_cmd.commit) begin
                r_bitmap[w_col] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_head    <= i_header_addr;
            r_rounded <= (i_header_addr + w_amask) & ~w_amask;
        end
        if (i_cmd.open_table) begin
            r_table <= TBL_W'(r_count);
        end
        if (i_cmd.find_group) begin
            r_group <= first_zero8(w_group_full);
        end
        if (i_cmd.commit) begin
            o_granted      <= 1'b1;
            o_handle_index <= INDEX_W'(w_handle);
            o_block_addr   <= r_rounded;
        end else if (i_cmd.fail) begin
            o_granted      <= 1'b0;
            o_handle_index <= '0;
            o_block_addr   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_entry[MEM_AW'(w_handle)] <= r_head;
        end
    end

    a_fail_only_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fail |-> (o_stat.at_limit && o_stat.need_table))
        else $error("allocation refused while a table was still available");

    a_commit_sets_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_bitmap[$past(w_col)])
        else $error("granted column not marked in bitmap");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TABLES))
        else $error("tables in use exceeds limit");

    a_commit_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !w_byte[w_col[GROUP_W-1:0]])
        else $error("granted column was already occupied");

endmodule

// ----- rtl/bitmap_handle_allocator.sv -----
// A granted request passes through table pick, byte search and column search
// with entry write; a refused request (all tables full at the limit) ends at
// the table pick. Busy stays high while a request is in flight, and a new start
// is taken only while busy is low. Results strobe for one cycle on o_done; the
// receiver cannot stall.
// Reset (synchronous, active low) empties all tables and sets alignment to 16.
module bitmap_handle_allocator
    import bha_pkg::*;
#(
    parameter int MAX_TABLES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic [ADDR_W-1:0]  i_header_addr,
    // result channel
    output logic               o_done,
    output logic               o_granted,
    output logic [INDEX_W-1:0] o_handle_index,
    output logic [ADDR_W-1:0]  o_block_addr,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [ALIGN_W-1:0] r_align_log2;
    logic               w_reg_hit;
    t_cmd               w_cmd;
    t_stat              w_stat;

    // Registers sit on 32-bit words; drop the byte offset for the decode.
    assign w_reg_hit = (paddr[PADDR_W-1:2] == REG_ALIGN);
    assign pready    = 1'b1;

    // Take the alignment exponent on the access phase of a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align_log2 <= ALIGN_RESET;
        end else if (psel && penable && pwrite && w_reg_hit) begin
            r_align_log2 <= pwdata[ALIGN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_hit) begin
            prdata = DATA_W'(r_align_log2);
        end
    end

    // Sequencer: one request in flight, advanced through pick/search/commit.
    bha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Table state, column search, alignment rounding and entry store.
    bha_dpath #(
        .MAX_TABLES (MAX_TABLES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_header_addr  (i_header_addr),
        .i_align_log2   (r_align_log2),
        .o_stat         (w_stat),
        .o_done         (o_done),
        .o_granted      (o_granted),
        .o_handle_index (o_handle_index),
        .o_block_addr   (o_block_addr)
    );

endmodule
